>>> design/aim_angle_from_positions_core_macros.svh
// assertion macros shared by the checker
`ifndef AIM_ANGLE_FROM_POSITIONS_CORE_MACROS_SVH
`define AIM_ANGLE_FROM_POSITIONS_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define AAFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define AAFP_NEVER(label, cond, msg) \
  `AAFP_ASSERT(label, !(cond), msg)

`endif

>>> design/aafp_pkg.sv
// shared constants and the arctangent table for the aim angle core
`timescale 1ns / 1ps
package aafp_pkg;

  localparam int XW       = 46;  // cordic vector width
  localparam int ZW       = 26;  // angle accumulator width, degrees with 16 fraction bits
  localparam int DW       = 33;  // position difference width
  localparam int CW       = 42;  // normalized component width
  localparam int AccFrac  = 16;
  localparam int NormTop  = 39;
  localparam logic [20:0] GainQ20 = 21'd1726753;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 26'sd2949120;
      1:  r = 26'sd1740967;
      2:  r = 26'sd919879;
      3:  r = 26'sd466945;
      4:  r = 26'sd234379;
      5:  r = 26'sd117304;
      6:  r = 26'sd58666;
      7:  r = 26'sd29335;
      8:  r = 26'sd14668;
      9:  r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      20: r = 26'sd4;
      21: r = 26'sd2;
      22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/aafp_cordic_cell.sv
// one vectoring cordic iteration, registered, with a sideband that rides along
`timescale 1ns / 1ps
module aafp_cordic_cell
  import aafp_pkg::*;
#(
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic [SW-1:0]        side_o
);

  localparam logic signed [ZW-1:0] Atan = atan_deg(STEP);

  logic                 valid_q;
  logic signed [XW-1:0] x_d, x_q, y_d, y_q, xs, ys;
  logic signed [ZW-1:0] z_d, z_q;
  logic [SW-1:0]        side_q;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Atan;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

>>> design/aim_angle_from_positions_core.sv
// aim angle core: difference vector, two cordic chains, rounding and wrap
`timescale 1ns / 1ps
// Fully pipelined: one query may be started in every cycle and busy_o never rises.
// Each result appears on done_o after the six front stages (difference, magnitude,
// leading-one search, normalize, gain multiply, gain rounding), the two chains of
// CORDIC_STEPS cordic cells (yaw, then pitch) and two output stages. The receiver
// cannot stall, so every result must be taken in the one cycle that done_o is high.
module aim_angle_from_positions_core
  import aafp_pkg::*;
#(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] own_x_i,
  input  logic signed [31:0] own_y_i,
  input  logic signed [31:0] own_z_i,
  input  logic signed [14:0] view_pitch_i,
  input  logic signed [15:0] view_yaw_i,
  output logic               done_o,
  output logic signed [14:0] abs_pitch_o,
  output logic signed [15:0] abs_yaw_o,
  output logic signed [15:0] rel_pitch_o,
  output logic signed [15:0] rel_yaw_o
);

  localparam int N   = CORDIC_STEPS;
  localparam int Rs  = AccFrac - ANGLE_FRAC_BITS;
  localparam int SW1 = XW + 32;
  localparam int SW2 = ZW + 32;
  localparam logic signed [18:0] HalfTurn = 19'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [18:0] FullTurn = 19'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [15:0] Lim      = 16'(89 << ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] RndHalf = ZW'(1 << (Rs - 1));

  logic [5:0] v_q;
  logic [1:0] f_v_q;

  // front stage payload
  logic signed [DW-1:0] dx_d, dy_d, dz_d, dx0_q, dy0_q, dz0_q;
  logic signed [DW-1:0] dx1_q, dy1_q, dz1_q, dx2_q, dy2_q, dz2_q;
  logic [DW-1:0]        mag_or_d, mag_or_q;
  logic [5:0]           sh_d, sh_q;
  logic signed [CW-1:0] cx_d, cy_d, cz_d, cx3_q, cy3_q, cz3_q, cx4_q, cy4_q, cx5_q, cy5_q;
  logic signed [CW-1:0] xe, ye;
  logic signed [63:0]   prod_d, prod_q, prod_rnd;
  logic signed [XW-1:0] gz_q;
  logic [5:0]           neg_q;
  logic signed [14:0]   vp_q [6];
  logic signed [15:0]   vy_q [6];

  assign busy_o = 1'b0;

  // stage 0: difference vector, zero dx nudged by one lsb
  always_comb begin
    dx_d = {target_x_i[31], target_x_i} - {own_x_i[31], own_x_i};
    dy_d = {target_y_i[31], target_y_i} - {own_y_i[31], own_y_i};
    dz_d = {target_z_i[31], target_z_i} - {own_z_i[31], own_z_i};
    if (dx_d == '0) begin
      dx_d = DW'(1);
    end
  end

  // stage 1: or of magnitudes has the same leading one as their maximum
  always_comb begin
    mag_or_d = (dx0_q[DW-1] ? DW'(-dx0_q) : DW'(dx0_q))
             | (dy0_q[DW-1] ? DW'(-dy0_q) : DW'(dy0_q))
             | (dz0_q[DW-1] ? DW'(-dz0_q) : DW'(dz0_q));
  end

  // stage 2: leading-one search gives the normalizing shift
  always_comb begin
    logic [5:0] b;
    b = '0;
    for (int i = 0; i < DW; i++) begin
      if (mag_or_q[i]) begin
        b = 6'(i);
      end
    end
    sh_d = 6'(NormTop) - b;
  end

  // stage 3: shift and mirror into the right half plane
  always_comb begin
    xe   = {{(CW-DW){dx2_q[DW-1]}}, dx2_q} <<< sh_q;
    ye   = {{(CW-DW){dy2_q[DW-1]}}, dy2_q} <<< sh_q;
    cz_d = {{(CW-DW){dz2_q[DW-1]}}, dz2_q} <<< sh_q;
    cx_d = neg_q[2] ? -xe : xe;
    cy_d = neg_q[2] ? -ye : ye;
  end

  assign prod_d   = cz3_q * $signed({1'b0, GainQ20});
  assign prod_rnd = prod_q + 64'sd524288;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dx0_q <= dx_d;  dy0_q <= dy_d;  dz0_q <= dz_d;
    dx1_q <= dx0_q; dy1_q <= dy0_q; dz1_q <= dz0_q;
    dx2_q <= dx1_q; dy2_q <= dy1_q; dz2_q <= dz1_q;
    mag_or_q <= mag_or_d;
    sh_q     <= sh_d;
    cx3_q <= cx_d;  cy3_q <= cy_d;  cz3_q <= cz_d;
    cx4_q <= cx3_q; cy4_q <= cy3_q;
    prod_q <= prod_d;
    cx5_q <= cx4_q; cy5_q <= cy4_q;
    gz_q  <= XW'(prod_rnd >>> 20);
    neg_q <= {neg_q[4:0], dx_d[DW-1]};
    vp_q[0] <= view_pitch_i;
    vy_q[0] <= view_yaw_i;
    for (int k = 1; k < 6; k++) begin
      vp_q[k] <= vp_q[k-1];
      vy_q[k] <= vy_q[k-1];
    end
  end

  // yaw chain
  logic                 yv [N+1];
  logic signed [XW-1:0] yx [N+1];
  logic signed [XW-1:0] yy [N+1];
  logic signed [ZW-1:0] yz [N+1];
  logic [SW1-1:0]       ys [N+1];

  assign yv[0] = v_q[5];
  assign yx[0] = XW'(cx5_q);
  assign yy[0] = XW'(cy5_q);
  assign yz[0] = '0;
  assign ys[0] = {gz_q, neg_q[5], vp_q[5], vy_q[5]};

  // pitch chain
  logic                 pv [N+1];
  logic signed [XW-1:0] px [N+1];
  logic signed [XW-1:0] py [N+1];
  logic signed [ZW-1:0] pz [N+1];
  logic [SW2-1:0]       ps [N+1];

  assign pv[0] = yv[N];
  assign px[0] = yx[N];
  assign py[0] = ys[N][SW1-1 -: XW];
  assign pz[0] = '0;
  assign ps[0] = {yz[N], ys[N][31:0]};

  for (genvar g = 0; g < N; g++) begin : g_cells
    aafp_cordic_cell #(.STEP(g), .SW(SW1)) u_yaw (
      .clk_i, .rst_ni,
      .valid_i(yv[g]),   .x_i(yx[g]),   .y_i(yy[g]),   .z_i(yz[g]),   .side_i(ys[g]),
      .valid_o(yv[g+1]), .x_o(yx[g+1]), .y_o(yy[g+1]), .z_o(yz[g+1]), .side_o(ys[g+1])
    );
    aafp_cordic_cell #(.STEP(g), .SW(SW2)) u_pitch (
      .clk_i, .rst_ni,
      .valid_i(pv[g]),   .x_i(px[g]),   .y_i(py[g]),   .z_i(pz[g]),   .side_i(ps[g]),
      .valid_o(pv[g+1]), .x_o(px[g+1]), .y_o(py[g+1]), .z_o(pz[g+1]), .side_o(ps[g+1])
    );
  end

  // finish stage 1: round, unmirror yaw, wrap, clamp pitch
  logic signed [ZW-1:0] yaw_rnd, pit_rnd;
  logic signed [18:0]   ayaw_raw, ayaw_d, ayaw_q;
  logic signed [15:0]   apit_d, apit_q;
  logic signed [14:0]   vp_f_q;
  logic signed [15:0]   vy_f_q;
  logic signed [18:0]   ry_raw, ry_d;
  logic signed [16:0]   rp_d;

  always_comb begin
    yaw_rnd  = ($signed(ps[N][SW2-1 -: ZW]) + RndHalf) >>> Rs;
    pit_rnd  = (pz[N] + RndHalf) >>> Rs;
    ayaw_raw = 19'(yaw_rnd) + (ps[N][31] ? HalfTurn : 19'sd0);
    if (ayaw_raw >= HalfTurn) begin
      ayaw_d = ayaw_raw - FullTurn;
    end else if (ayaw_raw <= -HalfTurn) begin
      ayaw_d = ayaw_raw + FullTurn;
    end else begin
      ayaw_d = ayaw_raw;
    end
    apit_d = -16'(pit_rnd);
    if (apit_d > Lim) begin
      apit_d = Lim;
    end else if (apit_d < -Lim) begin
      apit_d = -Lim;
    end
  end

  // finish stage 2: relative angles
  always_comb begin
    rp_d   = 17'(apit_q) - 17'(vp_f_q);
    ry_raw = ayaw_q - 19'(vy_f_q);
    if (ry_raw >= HalfTurn) begin
      ry_d = ry_raw - FullTurn;
    end else if (ry_raw <= -HalfTurn) begin
      ry_d = ry_raw + FullTurn;
    end else begin
      ry_d = ry_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= '0;
    end else begin
      f_v_q <= {f_v_q[0], pv[N]};
    end
  end

  always_ff @(posedge clk_i) begin
    ayaw_q      <= ayaw_d;
    apit_q      <= apit_d;
    vp_f_q      <= ps[N][30:16];
    vy_f_q      <= ps[N][15:0];
    abs_pitch_o <= 15'(apit_q);
    abs_yaw_o   <= 16'(ayaw_q);
    rel_pitch_o <= 16'(rp_d);
    rel_yaw_o   <= 16'(ry_d);
  end

  assign done_o = f_v_q[1];

endmodule

>>> design/aafp_checker.sv
// port-level checks for the aim angle core, bound to the top level
`timescale 1ns / 1ps
`include "aim_angle_from_positions_core_macros.svh"
module aafp_checker #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic signed [14:0] abs_pitch_o,
  input logic signed [15:0] abs_yaw_o
);

  localparam int Lat = 2 * CORDIC_STEPS + 8;
  localparam logic signed [15:0] Lim  = 16'(89 << ANGLE_FRAC_BITS);
  localparam logic signed [16:0] Half = 17'(180 << ANGLE_FRAC_BITS);

  `AAFP_NEVER(a_never_busy, busy_o, "core raised busy")
  `AAFP_ASSERT(a_beat_out, start_i |-> ##Lat done_o, "started beat did not come out")
  `AAFP_ASSERT(a_no_extra, done_o |-> $past(start_i, Lat), "result beat without a start")
  `AAFP_ASSERT(a_pitch_rng, done_o |-> (16'(abs_pitch_o) <= Lim && 16'(abs_pitch_o) >= -Lim),
               "pitch outside clamp")
  `AAFP_ASSERT(a_yaw_rng, done_o |-> (17'(abs_yaw_o) < Half && 17'(abs_yaw_o) >= -Half),
               "yaw not wrapped")

endmodule

bind aim_angle_from_positions_core aafp_checker #(
  .CORDIC_STEPS(CORDIC_STEPS),
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_aafp_checker (.*);

>>> sim/testbench.sv
// testbench for the aim angle core: random and directed queries against an in-bench predictor
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [14:0] abs_pitch;
  logic signed [15:0] abs_yaw;
  logic signed [15:0] rel_pitch;
  logic signed [15:0] rel_yaw;
} aim_angles_t;

class aim_scoreboard;
  aim_angles_t angles_q[$];
  int          errors;
  longint      atan_q16[16];

  function new();
    atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    errors = 0;
  endfunction

  // vectoring rotation toward the x axis; returns the angle, leaves |v|*gain in mag
  function automatic longint rotate_to_axis(longint x, longint y, output longint mag);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; ang += atan_q16[i];
      end else begin
        x = x - ys; y = y + xs; ang -= atan_q16[i];
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic longint round_angle(longint acc);
    return (acc + (64'sd1 <<< 8)) >>> 9;
  endfunction

  function automatic longint wrap_half_turn(longint a);
    if (a >= 23040) return a - 46080;
    if (a <= -23040) return a + 46080;
    return a;
  endfunction

  function automatic void note_query(logic signed [31:0] tx, logic signed [31:0] ty,
                                     logic signed [31:0] tz, logic signed [31:0] ox,
                                     logic signed [31:0] oy, logic signed [31:0] oz,
                                     logic signed [14:0] vp, logic signed [15:0] vy);
    longint dx, dy, dz, m, cx, cy, cz, r, gz, yaw_acc, pit_acc, ayaw, apit;
    int b, s;
    bit neg;
    aim_angles_t e;
    dx = longint'(tx) - longint'(ox);
    dy = longint'(ty) - longint'(oy);
    dz = longint'(tz) - longint'(oz);
    if (dx == 0) dx = 1;
    neg = dx < 0;
    m = neg ? -dx : dx;
    if ((dy < 0 ? -dy : dy) > m) m = dy < 0 ? -dy : dy;
    if ((dz < 0 ? -dz : dz) > m) m = dz < 0 ? -dz : dz;
    b = 0;
    while (b < 63 && (m >> (b + 1)) != 0) b++;
    s = (b <= 39) ? 39 - b : 0;
    cx = dx <<< s;
    cy = dy <<< s;
    cz = dz <<< s;
    if (neg) begin
      cx = -cx; cy = -cy;
    end
    yaw_acc = rotate_to_axis(cx, cy, r);
    gz = (cz * 64'sd1726753 + (64'sd1 <<< 19)) >>> 20;
    pit_acc = rotate_to_axis(r, gz, r);
    ayaw = round_angle(yaw_acc);
    if (neg) ayaw += 23040;
    ayaw = wrap_half_turn(ayaw);
    apit = -round_angle(pit_acc);
    if (apit > 11392) apit = 11392;
    if (apit < -11392) apit = -11392;
    e.abs_pitch = apit[14:0];
    e.abs_yaw   = ayaw[15:0];
    e.rel_pitch = 16'(apit - longint'(vp));
    e.rel_yaw   = 16'(wrap_half_turn(ayaw - longint'(vy)));
    angles_q.push_back(e);
  endfunction

  function automatic void check_result(aim_angles_t got);
    aim_angles_t e;
    if (angles_q.size() == 0) begin
      $error("result beat with no query outstanding");
      errors++;
      return;
    end
    e = angles_q.pop_front();
    if (got.abs_pitch !== e.abs_pitch) begin
      $error("abs_pitch expected %0d actual %0d", e.abs_pitch, got.abs_pitch); errors++;
    end
    if (got.abs_yaw !== e.abs_yaw) begin
      $error("abs_yaw expected %0d actual %0d", e.abs_yaw, got.abs_yaw); errors++;
    end
    if (got.rel_pitch !== e.rel_pitch) begin
      $error("rel_pitch expected %0d actual %0d", e.rel_pitch, got.rel_pitch); errors++;
    end
    if (got.rel_yaw !== e.rel_yaw) begin
      $error("rel_yaw expected %0d actual %0d", e.rel_yaw, got.rel_yaw); errors++;
    end
  endfunction
endclass

module testbench;
  localparam int StallLimit = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [31:0] own_x_i = '0, own_y_i = '0, own_z_i = '0;
  logic signed [14:0] view_pitch_i = '0;
  logic signed [15:0] view_yaw_i = '0;
  logic               done_o;
  logic signed [14:0] abs_pitch_o;
  logic signed [15:0] abs_yaw_o, rel_pitch_o, rel_yaw_o;

  aim_scoreboard sb = new();
  int idle_cycles = 0;
  bit timed_out = 0;

  always #10 clk_i = ~clk_i;

  aim_angle_from_positions_core u_dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_query(target_x_i, target_y_i, target_z_i, own_x_i, own_y_i, own_z_i,
                      view_pitch_i, view_yaw_i);
      if (done_o)
        sb.check_result('{abs_pitch_o, abs_yaw_o, rel_pitch_o, rel_yaw_o});
      if ((start_i && !busy_o) || done_o)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit && !timed_out) begin
        timed_out = 1;
        $display("aim_angle_from_positions_core verification failed");
        $finish;
      end
    end
  end

  // drive one query beat and hold it until taken
  task automatic send_query(logic signed [31:0] tx, logic signed [31:0] ty,
                            logic signed [31:0] tz, logic signed [31:0] ox,
                            logic signed [31:0] oy, logic signed [31:0] oz,
                            logic signed [14:0] vp, logic signed [15:0] vy);
    bit held;
    start_i      <= 1'b1;
    target_x_i   <= tx; target_y_i <= ty; target_z_i <= tz;
    own_x_i      <= ox; own_y_i    <= oy; own_z_i    <= oz;
    view_pitch_i <= vp;
    view_yaw_i   <= vy;
    do begin
      @(negedge clk_i);
      held = busy_o;
      @(posedge clk_i);
    end while (held);
  endtask

  task automatic pause_sender(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 4000)) - 2000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 2000000)) - 1000000;
    endcase
  endfunction

  task automatic send_random_query();
    int mode;
    logic signed [31:0] ox, oy, oz, tx, ty, tz;
    logic signed [14:0] vp;
    logic signed [15:0] vy;
    mode = $urandom_range(0, 3);
    ox = pick_coord(mode); oy = pick_coord(mode); oz = pick_coord(mode);
    tx = pick_coord(mode); ty = pick_coord(mode); tz = pick_coord(mode);
    // zero components hit the nudge and the vertical cases
    if ($urandom_range(0, 9) == 0) tx = ox;
    if ($urandom_range(0, 14) == 0) ty = oy;
    if ($urandom_range(0, 14) == 0) tz = oz;
    if ($urandom_range(0, 9) == 0) begin
      vp = 15'($urandom()); vy = 16'($urandom());
    end else begin
      vp = 15'($signed($urandom_range(0, 22784)) - 11392);
      vy = 16'($signed($urandom_range(0, 46079)) - 23040);
    end
    send_query(tx, ty, tz, ox, oy, oz, vp, vy);
  endtask

  initial begin
    int burst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coincident, zero dx, vertical, extremes, wrap near 180
    send_query(0, 0, 0, 0, 0, 0, 0, 0);
    send_query(0, 500, 0, 0, 0, 0, 11392, -23040);
    send_query(0, -500, 0, 0, 0, 0, -11392, 23039);
    send_query(5, 7, 900, 5, 7, 0, 0, 0);
    send_query(5, 7, -900, 5, 7, 0, 100, -100);
    send_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
               32'sh80000000, 32'sh80000000, 32'sh80000000, 11392, 23039);
    send_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
               32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -11392, -23040);
    send_query(-1000, 1, 0, 0, 0, 0, 0, -23040);
    send_query(-1000, -1, 0, 0, 0, 0, 0, 23039);
    send_query(-1000, 0, 0, 0, 0, 0, -11392, 23039);
    send_query(1000, 0, 1000, 0, 0, 0, 0, 0);
    send_query(1, 1, 1, 0, 0, 0, 15'sh4000, 16'sh8000);
    send_query(-1, -1, -1, 0, 0, 0, 15'sh3fff, 16'sh7fff);
    send_query(32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 0, 0);
    send_query(0, 0, 32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0);
    send_query(-300, 300, 0, 0, 0, 0, 0, 23039);

    for (int n = 0; n < 1350;) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) send_random_query();
      n += burst;
      if (n >= 600 && n - burst < 600)
        while (sb.angles_q.size() != 0) pause_sender(1);
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 20));
    end
    start_i <= 1'b0;

    while (sb.angles_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0)
      $display("aim_angle_from_positions_core verification clean");
    else
      $display("aim_angle_from_positions_core verification failed");
    $finish;
  end
endmodule
